FILE: hw/rtl/jdls_pkg.sv
// Shared widths, register indexes and types for the joystick deadzone, lowpass and scaler.
`timescale 1ns / 1ps
package jdls_pkg;

  localparam int AXIS_W  = 16;
  localparam int DT_W    = 20;
  localparam int LIMIT_W = 16;
  localparam int TC_W    = 20;
  localparam int THR_W   = 15;
  localparam int VEL_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int DEN_W   = DT_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_CONSTANT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE      = 2'd3;

  localparam logic [LIMIT_W-1:0] LINEAR_LIMIT_RST  = 16'd0;
  localparam logic [LIMIT_W-1:0] ANGULAR_LIMIT_RST = 16'd0;
  localparam logic [TC_W-1:0]    TIME_CONSTANT_RST = 20'd200000;
  localparam logic [THR_W-1:0]   DEADZONE_RST      = 15'd1638;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [VEL_W-1:0]  vel_t;
  typedef logic [GAIN_W-1:0]        gain_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/jdls_if.sv
// Valid/ready channel interfaces for stick samples and velocity results.
`timescale 1ns / 1ps
interface jdls_sample_if import jdls_pkg::*; (input logic clk);
  logic               valid;
  logic               ready;
  axis_t              axis_forward_raw;
  axis_t              axis_side_raw;
  axis_t              axis_turn_raw;
  logic [DT_W-1:0]    elapsed_time;

  modport source (output valid, axis_forward_raw, axis_side_raw, axis_turn_raw,
                  elapsed_time, input ready);
  modport sink (input valid, axis_forward_raw, axis_side_raw, axis_turn_raw,
                elapsed_time, output ready);
endinterface

interface jdls_velocity_if import jdls_pkg::*; (input logic clk);
  logic valid;
  logic ready;
  vel_t linear_forward;
  vel_t linear_side;
  vel_t angular_turn;

  modport source (output valid, linear_forward, linear_side, angular_turn, input ready);
  modport sink (input valid, linear_forward, linear_side, angular_turn, output ready);
endinterface

FILE: hw/rtl/jdls_div.sv
// Restoring divider forming the Q0.16 lowpass gain dt / (dt + T), one bit per cycle.
`timescale 1ns / 1ps
module jdls_div import jdls_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DT_W-1:0]  dt,
  input  logic [DEN_W-1:0] den,
  output gain_t            quot,
  output div_stat_t        stat
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_hold;
  logic [3:0]       cnt;
  logic [DEN_W:0]   shifted;
  logic             fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        den_hold <= den;
        if (den == '0) begin
          quot      <= '0;
          stat.done <= 1'b1;
        end else if ({1'b0, dt} >= den) begin
          quot      <= '1;
          stat.done <= 1'b1;
        end else begin
          rem       <= {1'b0, dt};
          quot      <= '0;
          cnt       <= 4'd15;
          stat.busy <= 1'b1;
        end
      end else if (stat.busy) begin
        rem  <= fits ? DEN_W'(shifted - {1'b0, den_hold}) : shifted[DEN_W-1:0];
        quot <= {quot[GAIN_W-2:0], fits};
        cnt  <= cnt - 4'd1;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/jdls_mul.sv
// Shared signed 17 by 17 multiplier with a registered product.
`timescale 1ns / 1ps
module jdls_mul import jdls_pkg::*; (
  input  logic                      clk,
  input  logic signed [VEL_W-1:0]   a,
  input  logic signed [VEL_W-1:0]   b,
  output logic signed [2*VEL_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: hw/rtl/joystick_deadzone_lowpass_scaler.sv
// Top level: deadzone, first-order lowpass and velocity scaling of three stick axes.
//
// samples carries one tick: three Q1.15 axes and the microseconds since the
// last tick. velocity returns one beat per tick: forward and side velocity in
// mm/s and turn rate in mrad/s. The cfg port writes the four registers
// (linear limit, angular limit, time constant, deadzone); the user must
// write them only while idle, as the block itself does not enforce it.
// A tick is latched, runs through the bit-serial gain divider, then makes six
// passes through the one shared multiplier (three filter updates, three
// scalings) before the output register is loaded. samples.ready is high
// only between ticks, so a new tick is not taken until the last one has
// reached the output register.
// The output register lets the next tick be accepted while a result waits;
// if velocity is stalled the block holds its finished result until the beat
// leaves. Synchronous reset clears the filter state, restores the register
// defaults and drops any pending result.
`timescale 1ns / 1ps
module joystick_deadzone_lowpass_scaler import jdls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  jdls_sample_if.sink           samples,
  jdls_velocity_if.source       velocity,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_GAIN,
    S_MUL,
    S_RND,
    S_OUT
  } state_t;

  state_t state;

  logic [LIMIT_W-1:0] linear_limit;
  logic [LIMIT_W-1:0] angular_limit;
  logic [TC_W-1:0]    time_constant;
  logic [THR_W-1:0]   deadzone;

  axis_t            x [3];
  axis_t            fy [3];
  vel_t             res [3];
  logic [DT_W-1:0]  dt;
  logic [2:0]       op;
  logic [1:0]       idx;
  logic             div_start;
  logic             accept;

  gain_t                      gain;
  div_stat_t                  div_stat;
  logic signed [VEL_W-1:0]    mul_a;
  logic signed [VEL_W-1:0]    mul_b;
  logic signed [2*VEL_W-1:0]  prod;
  logic signed [2*VEL_W:0]    prod_ext;
  logic signed [2*VEL_W:0]    step_sum;
  logic signed [2*VEL_W:0]    scale_sum;
  logic signed [AXIS_W+1:0]   y_next;

  function automatic axis_t negate_sat(axis_t v);
    return (v == axis_t'(-32768)) ? axis_t'(32767) : axis_t'(-v);
  endfunction

  function automatic axis_t dead(axis_t v, logic [THR_W-1:0] thr);
    logic [AXIS_W-1:0] mag;
    mag = v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
    return (mag < {1'b0, thr}) ? '0 : v;
  endfunction

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;

  jdls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dt    (dt),
    .den   (DEN_W'(dt) + DEN_W'(time_constant)),
    .quot  (gain),
    .stat  (div_stat)
  );

  assign idx   = (op < 3'd3) ? op[1:0] : 2'(op - 3'd3);
  assign mul_a = (op < 3'd3) ? VEL_W'(x[idx]) - VEL_W'(fy[idx]) : VEL_W'(fy[idx]);
  assign mul_b = (op < 3'd3) ? signed'({1'b0, gain})
               : (op == 3'd5) ? signed'({1'b0, angular_limit})
               : signed'({1'b0, linear_limit});

  jdls_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_ext  = signed'({prod[2*VEL_W-1], prod});
  assign step_sum  = (prod_ext + 35'sd32768) >>> 16;
  assign scale_sum = (prod_ext + 35'sd16384) >>> 15;
  assign y_next    = (AXIS_W+2)'(fy[idx]) + step_sum[AXIS_W+1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      linear_limit  <= LINEAR_LIMIT_RST;
      angular_limit <= ANGULAR_LIMIT_RST;
      time_constant <= TIME_CONSTANT_RST;
      deadzone      <= DEADZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINEAR_LIMIT:  linear_limit  <= cfg_data[LIMIT_W-1:0];
        REG_ANGULAR_LIMIT: angular_limit <= cfg_data[LIMIT_W-1:0];
        REG_TIME_CONSTANT: time_constant <= cfg_data[TC_W-1:0];
        REG_DEADZONE:      deadzone      <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      div_start      <= 1'b0;
      op             <= '0;
      velocity.valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        fy[i] <= '0;
      end
    end else begin
      div_start <= 1'b0;
      if (velocity.valid && velocity.ready) begin
        velocity.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            x[0]      <= dead(samples.axis_forward_raw, deadzone);
            x[1]      <= dead(negate_sat(samples.axis_side_raw), deadzone);
            x[2]      <= dead(negate_sat(samples.axis_turn_raw), deadzone);
            dt        <= samples.elapsed_time;
            div_start <= 1'b1;
            op        <= '0;
            state     <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (div_stat.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_RND;
        end
        S_RND: begin
          if (op < 3'd3) begin
            fy[idx] <= y_next[AXIS_W-1:0];
          end else begin
            res[idx] <= scale_sum[VEL_W-1:0];
          end
          op    <= op + 3'd1;
          state <= (op == 3'd5) ? S_OUT : S_MUL;
        end
        S_OUT: begin
          if (!velocity.valid || velocity.ready) begin
            velocity.linear_forward <= res[0];
            velocity.linear_side    <= res[1];
            velocity.angular_turn   <= res[2];
            velocity.valid          <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("block ready again right after taking a tick");

  a_div_done_in_gain: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_GAIN))
    else $error("gain divider finished outside the gain wait");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && velocity.valid && !velocity.ready) |=> (state == S_OUT))
    else $error("finished result left while the output beat was stalled");
`endif

endmodule

FILE: sim/jdls_velocity_checker.sv
// Velocity checker: predicts each velocity beat from the accepted samples and compares.
`timescale 1ns / 1ps
module jdls_velocity_checker import jdls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  jdls_sample_if                samples,
  jdls_velocity_if              velocity,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    vel_t fwd;
    vel_t side;
    vel_t turn;
  } velocity_beat_t;

  velocity_beat_t expected_velocity[$];

  logic [LIMIT_W-1:0] lin_limit;
  logic [LIMIT_W-1:0] ang_limit;
  logic [TC_W-1:0]    time_const;
  logic [THR_W-1:0]   dz_thr;
  axis_t              held_fwd;
  axis_t              held_side;
  axis_t              held_turn;

  function automatic axis_t negate_clip(axis_t v);
    longint n;
    n = -longint'(v);
    return (n > 32767) ? axis_t'(32767) : axis_t'(n);
  endfunction

  function automatic axis_t deadzone(axis_t v, logic [THR_W-1:0] thr);
    longint mag;
    mag = (v < 0) ? -longint'(v) : longint'(v);
    return (mag < longint'(thr)) ? axis_t'(0) : v;
  endfunction

  function automatic gain_t gain_of(logic [DT_W-1:0] dt, logic [TC_W-1:0] tc);
    longint den;
    longint q;
    den = longint'(dt) + longint'(tc);
    if (den == 0) begin
      return gain_t'(0);
    end
    q = (longint'(dt) << 16) / den;
    return (q > 65535) ? gain_t'(65535) : gain_t'(q);
  endfunction

  function automatic axis_t filter_step(axis_t x, axis_t y, gain_t g);
    longint p;
    p = (longint'(x) - longint'(y)) * longint'(g) + 32768;
    return axis_t'(longint'(y) + (p >>> 16));
  endfunction

  function automatic vel_t scale_velocity(axis_t y, logic [LIMIT_W-1:0] lim);
    longint p;
    p = longint'(y) * longint'(lim) + 16384;
    return vel_t'(p >>> 15);
  endfunction

  task automatic check_field(input string name, input vel_t want, input vel_t got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    velocity_beat_t want;
    gain_t g;
    if (rst) begin
      lin_limit = LINEAR_LIMIT_RST;
      ang_limit = ANGULAR_LIMIT_RST;
      time_const = TIME_CONSTANT_RST;
      dz_thr = DEADZONE_RST;
      held_fwd = 0;
      held_side = 0;
      held_turn = 0;
      expected_velocity.delete();
    end else begin
      if (velocity.valid && velocity.ready) begin
        if (expected_velocity.size() == 0) begin
          errors++;
          $display("%0t: velocity beat with none expected, got %0d %0d %0d", $time,
                   velocity.linear_forward, velocity.linear_side, velocity.angular_turn);
        end else begin
          want = expected_velocity.pop_front();
          check_field("linear_forward", want.fwd, velocity.linear_forward);
          check_field("linear_side", want.side, velocity.linear_side);
          check_field("angular_turn", want.turn, velocity.angular_turn);
        end
      end
      if (samples.valid && samples.ready) begin
        g = gain_of(samples.elapsed_time, time_const);
        held_fwd = filter_step(deadzone(samples.axis_forward_raw, dz_thr), held_fwd, g);
        held_side = filter_step(deadzone(negate_clip(samples.axis_side_raw), dz_thr),
                                held_side, g);
        held_turn = filter_step(deadzone(negate_clip(samples.axis_turn_raw), dz_thr),
                                held_turn, g);
        want.fwd = scale_velocity(held_fwd, lin_limit);
        want.side = scale_velocity(held_side, lin_limit);
        want.turn = scale_velocity(held_turn, ang_limit);
        expected_velocity.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_LINEAR_LIMIT:  lin_limit = cfg_data[LIMIT_W-1:0];
          REG_ANGULAR_LIMIT: ang_limit = cfg_data[LIMIT_W-1:0];
          REG_TIME_CONSTANT: time_const = cfg_data[TC_W-1:0];
          REG_DEADZONE:      dz_thr = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_velocity.size();
  end

endmodule

FILE: sim/joystick_deadzone_lowpass_scaler_test.sv
// Testbench top: clock, reset, sample and register stimulus, velocity back-pressure, verdict.
`timescale 1ns / 1ps
module joystick_deadzone_lowpass_scaler_test;
  import jdls_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 250;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int errors;
  int pending;
  int quiet;
  int cur_thr;
  bit steady;
  int hold_requests;
  int holds_done;
  int hold_left;

  jdls_sample_if   samples_if (clk);
  jdls_velocity_if velocity_if (clk);

  joystick_deadzone_lowpass_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .velocity  (velocity_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  jdls_velocity_checker velocity_check (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples_if),
    .velocity  (velocity_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else if (rst || (samples_if.valid && samples_if.ready) ||
                 (velocity_if.valid && velocity_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    velocity_if.ready = 1'b0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        velocity_if.ready <= 1'b0;
        hold_left--;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
        velocity_if.ready <= 1'b0;
      end else begin
        velocity_if.ready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  function automatic axis_t pick_axis();
    case ($urandom_range(11))
      0: return axis_t'(32767);
      1: return axis_t'(-32767);
      2: return axis_t'(-32768);
      3: return axis_t'(cur_thr);
      4: return axis_t'(-cur_thr);
      5: return axis_t'(cur_thr - 1);
      6: return axis_t'(1 - cur_thr);
      7: return axis_t'(0);
      default: return axis_t'($urandom);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_dt(bit typical);
    if (typical && $urandom_range(99) < 85) begin
      return DT_W'($urandom_range(25000, 40000));
    end
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return DT_W'($urandom_range(1, 100));
      3: return DT_W'($urandom_range(1000, 300000));
      default: return DT_W'($urandom);
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return LIMIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [TC_W-1:0] pick_time_const();
    case ($urandom_range(5))
      0: return '0;
      1: return TC_W'(1);
      2: return '1;
      default: return TC_W'($urandom_range(10000, 400000));
    endcase
  endfunction

  function automatic logic [THR_W-1:0] pick_thr();
    case ($urandom_range(4))
      0: return '0;
      1: return '1;
      default: return THR_W'($urandom_range(0, 4000));
    endcase
  endfunction

  // Called and returns at a falling edge; valid stays high for the next beat.
  task automatic send_sample(input axis_t fwd, input axis_t side, input axis_t turn,
                             input logic [DT_W-1:0] dt);
    while (!steady && $urandom_range(99) < 17) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid <= 1'b1;
    samples_if.axis_forward_raw <= fwd;
    samples_if.axis_side_raw <= side;
    samples_if.axis_turn_raw <= turn;
    samples_if.elapsed_time <= dt;
    do begin
      @(posedge clk);
    end while (!(samples_if.valid && samples_if.ready));
    @(negedge clk);
  endtask

  task automatic drain();
    samples_if.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  // Upper data bits of the limit and deadzone writes carry junk that the block must drop.
  task automatic set_regs(input logic [LIMIT_W-1:0] lin, input logic [LIMIT_W-1:0] ang,
                          input logic [TC_W-1:0] tc, input logic [THR_W-1:0] thr);
    drain();
    write_reg(REG_LINEAR_LIMIT, {4'($urandom), lin});
    write_reg(REG_ANGULAR_LIMIT, {4'($urandom), ang});
    write_reg(REG_TIME_CONSTANT, tc);
    write_reg(REG_DEADZONE, {5'($urandom), thr});
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_thr = thr;
  endtask

  initial begin
    axis_t fwd;
    axis_t side;
    axis_t turn;
    int sent;
    int run;
    rst = 1'b1;
    steady = 1'b0;
    hold_requests = 0;
    cur_thr = DEADZONE_RST;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.axis_forward_raw = '0;
    samples_if.axis_side_raw = '0;
    samples_if.axis_turn_raw = '0;
    samples_if.elapsed_time = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_sample(12000, -12000, 5000, 33333);
    send_sample(-32768, -32768, -32768, '1);

    set_regs('1, '1, 1000, 1638);
    send_sample(32767, -32767, -32768, 1000);
    send_sample(-32768, 32767, 0, 1000);
    send_sample(1638, -1638, 1637, 50000);
    send_sample(-1637, 1639, -1638, 50000);
    send_sample(-32767, -32767, 32767, 0);
    send_sample(0, 0, 0, '1);
    send_sample(32767, 32767, 32767, 1);

    // zero time constant: gain saturates, or stays zero with no elapsed time
    set_regs('1, 1, 0, 0);
    send_sample(32767, -32768, -1, 5);
    send_sample(-32768, 1, 1, 0);
    send_sample(-1, -1, -1, '1);

    set_regs(1, '1, '1, '1);
    send_sample(32767, -32767, -32768, '1);
    send_sample(-32768, 32766, 32766, '1);
    send_sample(32766, -32768, 0, 1);

    set_regs(40000, 30000, 33333, 2000);
    send_sample(20000, -20000, 15000, 33333);
    send_sample(20000, -20000, 15000, 33333);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        set_regs('1, '1, 100000, pick_thr());
      end else begin
        set_regs(pick_limit(), pick_limit(), pick_time_const(), pick_thr());
      end
      steady = (phase == 1);
      if (phase == 3) begin
        hold_requests++;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        run = $urandom_range(1, 12);
        if ($urandom_range(99) < 85) begin
          fwd = pick_axis();
          side = pick_axis();
          turn = pick_axis();
          for (int k = 0; k < run; k++) begin
            send_sample(fwd, side, turn, pick_dt(1'b1));
            sent++;
          end
        end else begin
          for (int k = 0; k < run; k++) begin
            send_sample(pick_axis(), pick_axis(), pick_axis(), pick_dt(1'b0));
            sent++;
          end
        end
      end
    end

    steady = 1'b0;
    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
